[sv/dtq_pkg.sv]
package dtq_pkg;

	localparam int DEPTH     = 128;
	localparam int TIME_BITS = 48;
	localparam int SIZE_BITS = 16;

	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int OCC_W   = SIZE_BITS + $clog2(DEPTH);
	localparam int LIMIT_W = 8;
	localparam int BT_W    = 16;
	localparam int SPAN_W  = SIZE_BITS + BT_W;
	localparam int LOSTP_W = 32;
	localparam int LOSTB_W = 48;
	localparam int CMP_W   = (LIMIT_W > CNT_W) ? LIMIT_W + 1 : CNT_W + 1;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TIME   = CFG_IDX_W'(1);

	localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST = LIMIT_W'(128);
	localparam logic [BT_W-1:0]    BYTE_TIME_RST   = BT_W'(1600);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_ADD,
		ST_DROP,
		ST_PEAK,
		ST_EMIT
	} dtq_state_t;

	typedef struct packed {
		logic capture;
		logic retire;
		logic mul;
		logic add;
		logic drop;
		logic peak;
		logic load_out;
	} dtq_cmd_t;

	typedef struct packed {
		logic can_retire;
		logic has_room;
	} dtq_sts_t;

	typedef struct packed {
		logic                 accepted;
		logic [TIME_BITS-1:0] queue_delay;
		logic [CNT_W-1:0]     departed;
		logic [CNT_W-1:0]     occupancy_packets;
		logic [OCC_W-1:0]     occupancy_bytes;
		logic [CNT_W-1:0]     peak_packets;
		logic [OCC_W-1:0]     peak_bytes;
		logic [LOSTP_W-1:0]   lost_pkts;
		logic [LOSTB_W-1:0]   lost_bytes;
	} dtq_result_t;

endpackage

[sv/dtq_pkt_if.sv]
interface dtq_pkt_if;
	import dtq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] arrive_ns;
	logic [SIZE_BITS-1:0] packet_bytes;

	modport source (output valid, output arrive_ns, output packet_bytes, input ready);
	modport sink   (input valid, input arrive_ns, input packet_bytes, output ready);
endinterface

[sv/dtq_res_if.sv]
interface dtq_res_if;
	import dtq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 accepted;
	logic [TIME_BITS-1:0] queue_delay;
	logic [CNT_W-1:0]     departed;
	logic [CNT_W-1:0]     occupancy_packets;
	logic [OCC_W-1:0]     occupancy_bytes;
	logic [CNT_W-1:0]     peak_packets;
	logic [OCC_W-1:0]     peak_bytes;
	logic [LOSTP_W-1:0]   lost_pkts;
	logic [LOSTB_W-1:0]   lost_bytes;

	modport source (
		output valid, output accepted, output queue_delay, output departed,
		output occupancy_packets, output occupancy_bytes, output peak_packets,
		output peak_bytes, output lost_pkts, output lost_bytes, input ready
	);
	modport sink (
		input valid, input accepted, input queue_delay, input departed,
		input occupancy_packets, input occupancy_bytes, input peak_packets,
		input peak_bytes, input lost_pkts, input lost_bytes, output ready
	);
endinterface

[sv/dtq_cfg_if.sv]
interface dtq_cfg_if;
	import dtq_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/dtq_datapath.sv]
module dtq_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dtq_pkg::dtq_cmd_t              cmd,
	output dtq_pkg::dtq_sts_t              sts,
	input  logic [dtq_pkg::TIME_BITS-1:0]  arrive_ns,
	input  logic [dtq_pkg::SIZE_BITS-1:0]  packet_bytes,
	input  logic                           cfg_we,
	input  logic [dtq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dtq_pkg::CFG_DATA_W-1:0] cfg_data,
	output dtq_pkg::dtq_result_t           result
);
	import dtq_pkg::*;

	localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;
	localparam logic [LOSTP_W-1:0]   LOSTP_MAX = '1;
	localparam logic [LOSTB_W-1:0]   LOSTB_MAX = '1;

	// packet stores, one entry per held packet
	logic [TIME_BITS-1:0] finish_mem [DEPTH];
	logic [SIZE_BITS-1:0] size_mem   [DEPTH];
	logic [TIME_BITS-1:0] finish_rd_q;
	logic [SIZE_BITS-1:0] size_rd_q;

	logic [LIMIT_W-1:0]   queue_limit_q;
	logic [BT_W-1:0]      byte_time_q;

	logic [PTR_W-1:0]     head_q;
	logic [CNT_W-1:0]     count_q;
	logic [TIME_BITS-1:0] link_free_q;
	logic [OCC_W-1:0]     held_bytes_q;
	logic [CNT_W-1:0]     peak_pkts_q;
	logic [OCC_W-1:0]     peak_bytes_q;
	logic [LOSTP_W-1:0]   drop_count_q;
	logic [LOSTB_W-1:0]   drop_bytes_q;

	// per-item working registers
	logic [TIME_BITS-1:0] now_q;
	logic [SIZE_BITS-1:0] bytes_q;
	logic [CNT_W-1:0]     departed_q;
	logic [SPAN_W-1:0]    span_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] delay_q;
	logic                 accepted_q;

	logic [PTR_W-1:0]     head_next;
	logic [PTR_W:0]       tail_sum;
	logic [PTR_W-1:0]     tail;
	logic [TIME_BITS:0]   finish_sum;
	logic [TIME_BITS-1:0] finish;
	logic [LOSTB_W:0]     drop_sum;
	logic [CMP_W-1:0]     limit_ext;
	logic [CMP_W-1:0]     eff_limit;

	always_comb begin
		if (cmd.retire) begin
			head_next = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
		end else begin
			head_next = head_q;
		end
		tail_sum = {1'b0, head_q} + (PTR_W + 1)'(count_q);
		if (tail_sum >= (PTR_W + 1)'(DEPTH)) begin
			tail = PTR_W'(tail_sum - (PTR_W + 1)'(DEPTH));
		end else begin
			tail = tail_sum[PTR_W-1:0];
		end
		finish_sum = {1'b0, start_q} + (TIME_BITS + 1)'(span_q);
		finish     = finish_sum[TIME_BITS] ? TIME_MAX : finish_sum[TIME_BITS-1:0];
		drop_sum   = {1'b0, drop_bytes_q} + (LOSTB_W + 1)'(bytes_q);
		limit_ext  = CMP_W'(queue_limit_q);
		eff_limit  = (limit_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : limit_ext;
		sts.can_retire = (count_q != '0) && (finish_rd_q < now_q);
		sts.has_room   = CMP_W'(count_q) < eff_limit;
	end

	always_ff @(posedge clk) begin
		if (cmd.add) begin
			finish_mem[tail] <= finish;
			size_mem[tail]   <= bytes_q;
		end
		finish_rd_q <= finish_mem[head_next];
		size_rd_q   <= size_mem[head_next];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_limit_q <= QUEUE_LIMIT_RST;
			byte_time_q   <= BYTE_TIME_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_QUEUE_LIMIT) begin
				queue_limit_q <= cfg_data[LIMIT_W-1:0];
			end else if (cfg_index == CFG_BYTE_TIME) begin
				byte_time_q <= cfg_data[BT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			count_q      <= '0;
			link_free_q  <= '0;
			held_bytes_q <= '0;
			peak_pkts_q  <= '0;
			peak_bytes_q <= '0;
			drop_count_q <= '0;
			drop_bytes_q <= '0;
		end else begin
			head_q <= head_next;
			if (cmd.retire) begin
				count_q      <= count_q - CNT_W'(1);
				held_bytes_q <= held_bytes_q - OCC_W'(size_rd_q);
			end
			if (cmd.add) begin
				count_q      <= count_q + CNT_W'(1);
				held_bytes_q <= held_bytes_q + OCC_W'(bytes_q);
				link_free_q  <= finish;
			end
			if (cmd.drop) begin
				if (drop_count_q != LOSTP_MAX) begin
					drop_count_q <= drop_count_q + LOSTP_W'(1);
				end
				drop_bytes_q <= drop_sum[LOSTB_W] ? LOSTB_MAX : drop_sum[LOSTB_W-1:0];
			end
			if (cmd.peak) begin
				if (count_q > peak_pkts_q) begin
					peak_pkts_q <= count_q;
				end
				if (held_bytes_q > peak_bytes_q) begin
					peak_bytes_q <= held_bytes_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q      <= arrive_ns;
			bytes_q    <= packet_bytes;
			departed_q <= '0;
			accepted_q <= 1'b0;
			delay_q    <= '0;
		end
		if (cmd.retire) begin
			departed_q <= departed_q + CNT_W'(1);
		end
		if (cmd.mul) begin
			span_q  <= SPAN_W'(bytes_q) * SPAN_W'(byte_time_q);
			start_q <= (now_q > link_free_q) ? now_q : link_free_q;
		end
		if (cmd.add) begin
			accepted_q <= 1'b1;
			delay_q    <= start_q - now_q;
		end
		if (cmd.load_out) begin
			result.accepted          <= accepted_q;
			result.queue_delay       <= delay_q;
			result.departed          <= departed_q;
			result.occupancy_packets <= count_q;
			result.occupancy_bytes   <= held_bytes_q;
			result.peak_packets      <= peak_pkts_q;
			result.peak_bytes        <= peak_bytes_q;
			result.lost_pkts         <= drop_count_q;
			result.lost_bytes        <= drop_bytes_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("held count beyond depth");
	a_empty_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> held_bytes_q == '0)
		else $error("bytes held with empty queue");
	a_drop_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop |=> drop_count_q >= $past(drop_count_q) && drop_count_q != '0)
		else $error("drop count went backwards");
	a_add_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add |-> count_q < CNT_W'(DEPTH))
		else $error("write into a full queue");
`endif

endmodule

[sv/dtq_ctrl.sv]
module dtq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  dtq_pkg::dtq_sts_t sts,
	output dtq_pkg::dtq_cmd_t cmd
);
	import dtq_pkg::*;

	dtq_state_t state_q;
	dtq_state_t state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.can_retire) begin
					cmd.retire = 1'b1;
				end else if (sts.has_room) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_DROP;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ST_PEAK;
			end
			ST_DROP: begin
				cmd.drop = 1'b1;
				state_d  = ST_PEAK;
			end
			ST_PEAK: begin
				cmd.peak = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_CHECK)
		else $error("accepted item did not enter retire check");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !out_valid_q || out_ready)
		else $error("result register overwritten while held");
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.retire, cmd.add, cmd.drop, cmd.peak}))
		else $error("conflicting datapath commands");
`endif

endmodule

[sv/drop_tail_queue_link_model_unit.sv]
// Channel   Dir  Payload                                   Handshake
// pkt       in   arrive_ns, packet_bytes                   valid/ready
// res       out  accepted, queue_delay, departed,          valid/ready
//                occupancy_*, peak_*, lost_*
// cfg       in   index (0 queue_limit, 1 byte_time), data  valid/ready, ready tied high
//
// From accept, a buffered item passes the retire check and the multiply, add,
// peak and emit states; a dropped one the check, drop, peak and emit states.
// The retire loop in the check state reads one store entry per cycle.
// Reset clears control, counters and config (queue_limit 128, byte_time 1600);
// the packet stores are not cleared, only entries written are ever read.
// A stalled result waits in the output register while the next item is taken
// and worked on; that item then waits in its emit state until the slot frees.
module drop_tail_queue_link_model_unit (
	input logic      clk,
	input logic      arst_n,
	dtq_pkt_if.sink  pkt,
	dtq_res_if.source res,
	dtq_cfg_if.sink  cfg
);
	import dtq_pkg::*;

	dtq_cmd_t    cmd;
	dtq_sts_t    sts;
	dtq_result_t result;

	// config writes land at once, block is idle by contract
	assign cfg.ready = 1'b1;

	dtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pkt.valid),
		.in_ready  (pkt.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dtq_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.arrive_ns    (pkt.arrive_ns),
		.packet_bytes (pkt.packet_bytes),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.result       (result)
	);

	// result fields straight off the output register
	assign res.accepted          = result.accepted;
	assign res.queue_delay       = result.queue_delay;
	assign res.departed          = result.departed;
	assign res.occupancy_packets = result.occupancy_packets;
	assign res.occupancy_bytes   = result.occupancy_bytes;
	assign res.peak_packets      = result.peak_packets;
	assign res.peak_bytes        = result.peak_bytes;
	assign res.lost_pkts         = result.lost_pkts;
	assign res.lost_bytes        = result.lost_bytes;

endmodule

[dv/dtq_link_checker.sv]
module dtq_link_checker (
	input  logic clk,
	input  logic arst_n,
	dtq_pkt_if   pkt,
	dtq_res_if   res,
	dtq_cfg_if   cfg,
	output int   n_wait,
	output int   n_fail
);
	timeunit 1ns;
	timeprecision 1ps;
	import dtq_pkg::*;

	localparam logic [TIME_BITS-1:0] T_MAX = '1;
	localparam int                   DUE_DEPTH = 16;

	// shadow of the buffer and link
	logic [TIME_BITS-1:0] fin_at  [DEPTH];
	logic [SIZE_BITS-1:0] size_at [DEPTH];
	logic [PTR_W-1:0]     head;
	int                   held;
	logic [TIME_BITS-1:0] link_free;
	logic [OCC_W-1:0]     held_bytes;
	int                   peak_pkts;
	logic [OCC_W-1:0]     peak_b;
	logic [LOSTP_W-1:0]   lost_p;
	logic [LOSTB_W-1:0]   lost_b;
	logic [LIMIT_W-1:0]   limit;
	logic [BT_W-1:0]      byte_ns;

	// expected results in order, ring with free-running indexes
	dtq_result_t due_buf [DUE_DEPTH];
	int          due_wr;
	int          due_rd;
	int          fails = 0;

	// retire finished packets, then buffer or drop the arrival
	function automatic dtq_result_t admit_packet(input logic [TIME_BITS-1:0] now,
		input logic [SIZE_BITS-1:0] nbytes);
		dtq_result_t          r;
		int                   cap;
		int                   gone;
		logic [SPAN_W-1:0]    span;
		logic [TIME_BITS:0]   sum;
		logic [TIME_BITS-1:0] start;
		logic [PTR_W-1:0]     tail;
		logic [LOSTB_W:0]     lb;
		r = '0;
		cap = (int'(limit) > DEPTH) ? DEPTH : int'(limit);
		gone = 0;
		while (held > 0 && fin_at[head] < now) begin
			held_bytes = held_bytes - OCC_W'(size_at[head]);
			head = head + 1'b1;
			held--;
			gone++;
		end
		if (held < cap) begin
			start = (now > link_free) ? now : link_free;
			span = SPAN_W'(nbytes) * SPAN_W'(byte_ns);
			sum = {1'b0, start} + (TIME_BITS + 1)'(span);
			tail = head + PTR_W'(held);
			fin_at[tail] = sum[TIME_BITS] ? T_MAX : sum[TIME_BITS-1:0];
			size_at[tail] = nbytes;
			link_free = fin_at[tail];
			held_bytes = held_bytes + OCC_W'(nbytes);
			held++;
			r.accepted = 1'b1;
			r.queue_delay = start - now;
		end else begin
			if (lost_p != '1)
				lost_p++;
			lb = {1'b0, lost_b} + (LOSTB_W + 1)'(nbytes);
			lost_b = lb[LOSTB_W] ? '1 : lb[LOSTB_W-1:0];
		end
		if (held > peak_pkts)
			peak_pkts = held;
		if (held_bytes > peak_b)
			peak_b = held_bytes;
		r.departed          = CNT_W'(gone);
		r.occupancy_packets = CNT_W'(held);
		r.occupancy_bytes   = held_bytes;
		r.peak_packets      = CNT_W'(peak_pkts);
		r.peak_bytes        = peak_b;
		r.lost_pkts         = lost_p;
		r.lost_bytes        = lost_b;
		return r;
	endfunction

	function automatic int field_miss(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dtq_result_t want;
		if (!arst_n) begin
			head       = '0;
			held       = 0;
			link_free  = '0;
			held_bytes = '0;
			peak_pkts  = 0;
			peak_b     = '0;
			lost_p     = '0;
			lost_b     = '0;
			limit      = QUEUE_LIMIT_RST;
			byte_ns    = BYTE_TIME_RST;
			due_wr     = 0;
			due_rd     = 0;
			n_wait <= 0;
			n_fail <= fails;
		end else begin
			if (res.valid && res.ready) begin
				if (due_wr == due_rd) begin
					$display("%0t result item with nothing outstanding", $time);
					fails++;
				end else begin
					want = due_buf[due_rd % DUE_DEPTH];
					due_rd++;
					fails += field_miss("accepted", want.accepted, res.accepted);
					fails += field_miss("queue_delay", want.queue_delay, res.queue_delay);
					fails += field_miss("departed", want.departed, res.departed);
					fails += field_miss("occupancy_packets", want.occupancy_packets,
						res.occupancy_packets);
					fails += field_miss("occupancy_bytes", want.occupancy_bytes,
						res.occupancy_bytes);
					fails += field_miss("peak_packets", want.peak_packets, res.peak_packets);
					fails += field_miss("peak_bytes", want.peak_bytes, res.peak_bytes);
					fails += field_miss("lost_pkts", want.lost_pkts, res.lost_pkts);
					fails += field_miss("lost_bytes", want.lost_bytes, res.lost_bytes);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_QUEUE_LIMIT: limit = LIMIT_W'(cfg.data);
					CFG_BYTE_TIME:   byte_ns = BT_W'(cfg.data);
					default: ;
				endcase
			end
			if (pkt.valid && pkt.ready) begin
				if (due_wr - due_rd >= DUE_DEPTH) begin
					$display("%0t too many items outstanding", $time);
					fails++;
				end
				due_buf[due_wr % DUE_DEPTH] = admit_packet(pkt.arrive_ns, pkt.packet_bytes);
				due_wr++;
			end
			n_wait <= due_wr - due_rd;
			n_fail <= fails;
		end
	end

endmodule

[dv/tb_drop_tail_queue_link_model_unit.sv]
module tb_drop_tail_queue_link_model_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import dtq_pkg::*;

	localparam int              RAND_ITEMS  = 1350;
	localparam int unsigned     CYCLE_LIMIT = 2_000_000;
	localparam longint unsigned T_TOP       = (64'd1 << TIME_BITS) - 1;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          quiet;        // no idling on either side
	bit          sender_idle;  // sender may insert gaps in this segment
	int          n_wait;
	int          n_fail;
	int unsigned cycles = 0;

	dtq_pkt_if pkt_ch();
	dtq_res_if res_ch();
	dtq_cfg_if cfg_ch();

	drop_tail_queue_link_model_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// watches all three channels, predicts and scores
	dtq_link_checker u_chk (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch),
		.n_wait (n_wait),
		.n_fail (n_fail)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result sink: ready high for a random stretch, then maybe a stall burst
	initial begin
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			res_ch.ready <= 1'b1;
			repeat (($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 40)) @(posedge clk);
			if (!quiet && $urandom_range(0, 1) == 1) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	end

	function automatic longint unsigned rand_upto(input longint unsigned hi);
		return {$urandom, $urandom} % (hi + 1);
	endfunction

	// mostly ordinary frame sizes, with zero, one and the max mixed in
	function automatic logic [SIZE_BITS-1:0] pick_size();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return SIZE_BITS'($urandom_range(0, 63));
		if (roll < 70)
			return SIZE_BITS'($urandom_range(64, 1518));
		if (roll < 85)
			return SIZE_BITS'($urandom);
		if (roll < 90)
			return '0;
		if (roll < 95)
			return '1;
		return SIZE_BITS'(1);
	endfunction

	// one packet item; valid is left high so back-to-back items need no toggle
	task automatic send_packet(input logic [TIME_BITS-1:0] at, input logic [SIZE_BITS-1:0] nb);
		if (sender_idle && !quiet && $urandom_range(0, 4) == 0) begin
			pkt_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		pkt_ch.valid        <= 1'b1;
		pkt_ch.arrive_ns    <= at;
		pkt_ch.packet_bytes <= nb;
		do @(posedge clk); while (!pkt_ch.ready);
	endtask

	// stop sending and wait for every outstanding result
	task automatic hold_until_drained();
		pkt_ch.valid <= 1'b0;
		@(posedge clk);
		while (n_wait != 0)
			@(posedge clk);
	endtask

	// only with the block idle: a stray unmapped write, then both registers
	task automatic configure(input logic [LIMIT_W-1:0] lim, input logic [BT_W-1:0] bt);
		logic [CFG_IDX_W-1:0]  idx [3];
		logic [CFG_DATA_W-1:0] val [3];
		idx = '{CFG_IDX_W'($urandom_range(2, 255)), CFG_QUEUE_LIMIT, CFG_BYTE_TIME};
		val = '{CFG_DATA_W'($urandom), CFG_DATA_W'(lim), CFG_DATA_W'(bt)};
		hold_until_drained();
		foreach (idx[k]) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[k];
			cfg_ch.data  <= val[k];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		longint unsigned now_ns;
		longint unsigned gap;
		longint unsigned span_est;
		longint unsigned base;
		logic [LIMIT_W-1:0]   lim;
		logic [BT_W-1:0]      bt;
		logic [SIZE_BITS-1:0] nb;
		int sent;
		int seg;
		int seg_len;
		int mode;

		arst_n              = 1'b0;
		pkt_ch.valid        = 1'b0;
		pkt_ch.arrive_ns    = '0;
		pkt_ch.packet_bytes = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		quiet               = 1'b0;
		sender_idle         = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset config (limit 128, 1600 ns/byte) ---
		send_packet(48'd0, 16'd0);                  // zero-size item, no link time
		send_packet(48'd0, 16'hFFFF);               // largest packet, finishes at 104856000
		send_packet(48'd0, 16'd1500);               // queues behind it
		send_packet(48'd104_856_000, 16'd100);      // arrives exactly at a finish: that one stays
		send_packet(48'd5, 16'd10);                 // out of order arrival
		send_packet(48'd1_000_000_000_000, 16'd64); // long silence drains the buffer

		// zero limit: everything is dropped, loss totals grow
		configure(8'd0, 16'hFFFF);
		send_packet(48'd1_000_000_001_000, 16'd1000);
		send_packet(48'd1_000_000_001_000, 16'hFFFF);

		// limit of one with zero byte time: finish equals start
		configure(8'd1, 16'd0);
		send_packet(48'd2_000_000_000_000, 16'd500);
		send_packet(48'd2_000_000_000_000, 16'd700); // not retired yet, so dropped
		send_packet(48'd2_000_000_000_001, 16'd0);

		// limit two, fastest link
		configure(8'd2, 16'd1);
		send_packet(48'd3_000_000_000_000, 16'hFFFF);
		send_packet(48'd3_000_000_000_000, 16'd1);
		send_packet(48'd3_000_000_000_000, 16'd1);  // full
		send_packet(48'd3_000_000_065_536, 16'd2);  // one retires, one still on the wire

		// --- random segments, each with its own config and load pattern ---
		now_ns = 0;
		sent   = 0;
		seg    = 0;
		while (sent < RAND_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       lim = LIMIT_W'($urandom_range(129, 255)); // above depth
				1:       lim = LIMIT_W'($urandom_range(1, 4));
				2:       lim = LIMIT_W'($urandom_range(0, 1));
				3:       lim = LIMIT_W'(DEPTH);
				default: lim = LIMIT_W'($urandom_range(5, 128));
			endcase
			case ($urandom_range(0, 7))
				0:       bt = BT_W'(1);
				1:       bt = '1;
				2:       bt = '0;
				3:       bt = BT_W'(8);
				4:       bt = BT_W'(80);
				default: bt = BT_W'($urandom_range(1, 4000));
			endcase
			mode    = $urandom_range(0, 3);
			seg_len = $urandom_range(60, 120);
			// first segment: back-to-back arrivals overfill a limit above depth
			if (seg == 0) begin
				lim     = '1;
				bt      = '1;
				mode    = 4;
				seg_len = 140;
			end
			configure(lim, bt);
			quiet       = (sent >= RAND_ITEMS - 150);
			sender_idle = ($urandom_range(0, 2) != 0);
			// each segment starts far later, walking the top time bits upward;
			// the first arrival then retires whatever was left
			base   = (longint'((seg < 14) ? seg : 14) << 44) | rand_upto((64'd1 << 44) - 1);
			now_ns = (base > now_ns) ? base : now_ns + 64'd1_000_000_000;
			span_est = longint'((bt == 0) ? 1 : bt) * 800;
			repeat (seg_len) begin
				case (mode)
					0:       gap = rand_upto(span_est / 2);  // overload
					1:       gap = rand_upto(span_est * 2);
					2:       gap = rand_upto(span_est * 8);  // light load
					3:       gap = ($urandom_range(0, 4) == 0) ? rand_upto(span_est * 200) : 0;
					default: gap = 0;
				endcase
				now_ns = now_ns + gap;
				nb = pick_size();
				if ($urandom_range(0, 29) == 0)
					send_packet(TIME_BITS'(now_ns - rand_upto((now_ns < 64'd1_000_000)
						? now_ns : 64'd1_000_000)), nb);
				else
					send_packet(TIME_BITS'(now_ns), nb);
				if ($urandom_range(0, 99) == 0)
					hold_until_drained();
				sent++;
			end
			seg++;
		end

		// --- top of the time range: finish times saturate and never retire ---
		quiet = 1'b1;
		configure(LIMIT_W'(DEPTH), '1);
		now_ns = T_TOP - rand_upto(64'hFFFF_FFFF);
		repeat (60) begin
			now_ns = now_ns + rand_upto(64'd2_000_000_000);
			if (now_ns > T_TOP)
				now_ns = T_TOP;
			send_packet(TIME_BITS'(now_ns), pick_size());
		end
		send_packet(TIME_BITS'(T_TOP), '0);
		send_packet(TIME_BITS'(T_TOP), '1);

		hold_until_drained();
		// quiet window: any stray result item is caught here
		repeat (50) @(posedge clk);
		if (n_fail == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
